// File: rtl/dtw_pkg.sv
// shared types and constants for the der tlv structure walker
// used by dtw_ctrl, dtw_datapath and der_tlv_structure_walker_top; no dependencies

package dtw_pkg;

    // stack geometry and length form limits
    localparam int MAX_DEPTH           = 16;
    localparam int LENGTH_OCTETS_LIMIT = 4;
    localparam int DEPTH_W             = $clog2(MAX_DEPTH + 1);
    localparam int IDX_W               = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    // field widths
    localparam int LEN_W  = 31;
    localparam int TAG_W  = 5;
    localparam int CLS_W  = 2;
    localparam int CNT_W  = 5;
    localparam int LOCT_W = 3;
    localparam int ACC_W  = 24;

    // configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-3:0] REG_MAX_LEN_OCT  = '0;
    localparam logic [LOCT_W-1:0]  MAX_LEN_OCT_RST  = LOCT_W'(4);
    localparam logic [LOCT_W-1:0]  LEN_OCT_LIMIT    = LOCT_W'(LENGTH_OCTETS_LIMIT);

    // identifier octet bit positions
    localparam int ID_CONS_BIT = 5;
    localparam int ID_CLS_LSB  = 6;

    // length octet layout
    localparam int LEN_LONG_BIT = 7;

    typedef enum logic [2:0] {
        EV_HEADER   = 3'd0,
        EV_HDR_DONE = 3'd1,
        EV_CONTENT  = 3'd2,
        EV_ERROR    = 3'd3,
        EV_IGNORED  = 3'd4
    } t_event;

    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_FIRST_PRIM = 3'd1,
        ERR_LEN_OCTETS = 3'd2,
        ERR_NEG_LEN    = 3'd3,
        ERR_OVERRUN    = 3'd4,
        ERR_OVERFLOW   = 3'd5
    } t_err;

    typedef enum logic [6:0] {
        PH_IDLE    = 7'b0000001,
        PH_ID      = 7'b0000010,
        PH_LENF    = 7'b0000100,
        PH_LENM    = 7'b0001000,
        PH_CONTENT = 7'b0010000,
        PH_DONE    = 7'b0100000,
        PH_ERR     = 7'b1000000
    } t_phase;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic pop_step;
        logic finish;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic pop_req;
        logic top_zero;
    } t_dp_status;

endpackage

// File: rtl/dtw_ctrl.sv
// controller for the der tlv walker: input/output handshake and level pop sequencing
// depends on dtw_pkg

module dtw_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    input  dtw_pkg::t_dp_status i_status,
    output dtw_pkg::t_dp_cmd    o_cmd
);

    typedef enum logic [1:0] {
        S_ACCEPT = 2'b01,
        S_POP    = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept;
    logic   slot_free;

    // a new byte needs an empty or draining result slot
    assign slot_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == S_ACCEPT) && slot_free);
    assign accept     = i_in_valid && !o_in_stall;

    // next state, commands and result valid
    always_comb begin
        n_state        = r_state;
        n_out_valid    = r_out_valid && i_out_stall;
        o_cmd.accept   = 1'b0;
        o_cmd.pop_step = 1'b0;
        o_cmd.finish   = 1'b0;
        unique case (r_state)
            S_ACCEPT: begin
                o_cmd.accept = accept;
                if (accept) begin
                    if (i_status.pop_req) begin
                        n_state = S_POP;
                    end else begin
                        n_out_valid = 1'b1;
                    end
                end
            end
            S_POP: begin
                if (i_status.top_zero) begin
                    o_cmd.pop_step = 1'b1;
                end else begin
                    o_cmd.finish = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_ACCEPT;
                end
            end
            default: begin
                n_state = S_ACCEPT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_ACCEPT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// File: rtl/dtw_datapath.sv
// datapath for the der tlv walker: header decode, length checks, level stack, result register
// depends on dtw_pkg; driven by dtw_ctrl commands

module dtw_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  dtw_pkg::t_dp_cmd                  i_cmd,
    output dtw_pkg::t_dp_status               o_status,
    input  logic [7:0]                        i_data_byte,
    input  logic                              i_start_req,
    input  logic [dtw_pkg::LOCT_W-1:0]        i_len_limit,
    output logic [2:0]                        o_event_res,
    output logic [dtw_pkg::TAG_W-1:0]         o_tag,
    output logic [dtw_pkg::CLS_W-1:0]         o_tag_class,
    output logic                              o_constructed,
    output logic [dtw_pkg::LEN_W-1:0]         o_content_length,
    output logic [dtw_pkg::CNT_W-1:0]         o_depth,
    output logic [dtw_pkg::CNT_W-1:0]         o_levels_closed,
    output logic                              o_finished,
    output logic [2:0]                        o_error_code
);

    localparam int DEPTH_W = dtw_pkg::DEPTH_W;
    localparam int IDX_W   = dtw_pkg::IDX_W;
    localparam int LEN_W   = dtw_pkg::LEN_W;
    localparam int CNT_W   = dtw_pkg::CNT_W;
    localparam int TAG_W   = dtw_pkg::TAG_W;
    localparam int CLS_W   = dtw_pkg::CLS_W;
    localparam int LOCT_W  = dtw_pkg::LOCT_W;
    localparam int ACC_W   = dtw_pkg::ACC_W;
    localparam logic [DEPTH_W-1:0] DEPTH_FULL = DEPTH_W'(dtw_pkg::MAX_DEPTH);

    // walker state
    dtw_pkg::t_phase     r_phase, n_phase;
    logic [7:0]          r_id, n_id;
    logic [ACC_W-1:0]    r_lacc, n_lacc;
    logic [LOCT_W-1:0]   r_lol, n_lol;
    logic [LEN_W-1:0]    r_cl, n_cl;
    logic [2:0]          r_hb, n_hb;
    logic [DEPTH_W-1:0]  r_open, n_open;
    dtw_pkg::t_err       r_err, n_err;
    logic [LEN_W-1:0]    r_top_rem, n_top_rem;
    logic [LEN_W-1:0]    r_top_tot, n_top_tot;

    // levels below the top of stack
    logic [LEN_W-1:0]    r_stk_rem [dtw_pkg::MAX_DEPTH];
    logic [LEN_W-1:0]    r_stk_tot [dtw_pkg::MAX_DEPTH];

    // result register
    dtw_pkg::t_event     r_ev, n_ev;
    logic [TAG_W-1:0]    r_tag, n_tag;
    logic [CLS_W-1:0]    r_cls, n_cls;
    logic                r_cons, n_cons;
    logic [LEN_W-1:0]    r_clen, n_clen;
    logic [CNT_W-1:0]    r_depth, n_depth;
    logic [CNT_W-1:0]    r_closed, n_closed;
    logic                r_fin, n_fin;
    dtw_pkg::t_err       r_ecode, n_ecode;

    // working signals
    logic [DEPTH_W-1:0]  open_m1, open_m2;
    logic [IDX_W-1:0]    idx_wr, idx_rd;
    logic [LEN_W-1:0]    rd_rem, rd_tot;
    logic                mem_we;
    logic [LEN_W-1:0]    mem_wrem;
    logic                fh;
    logic [LEN_W-1:0]    fh_len;
    logic [31:0]         need;
    logic [31:0]         acc;
    logic                raise;
    dtw_pkg::t_err       raise_code;
    logic                show_id;
    logic                pop_req;
    logic [LOCT_W-1:0]   lol_dec;
    logic [LEN_W-1:0]    cl_dec;

    // stack addressing: push below the top, pop from just below the top
    assign open_m1 = r_open - DEPTH_W'(1);
    assign open_m2 = r_open - DEPTH_W'(2);
    assign idx_wr  = open_m1[IDX_W-1:0];
    assign idx_rd  = open_m2[IDX_W-1:0];
    assign rd_rem  = r_stk_rem[idx_rd];
    assign rd_tot  = r_stk_tot[idx_rd];

    assign acc     = {r_lacc, i_data_byte};
    assign lol_dec = r_lol - LOCT_W'(1);
    assign cl_dec  = r_cl - LEN_W'(1);

    // byte decode, header completion and pop steps
    always_comb begin
        n_phase    = r_phase;
        n_id       = r_id;
        n_lacc     = r_lacc;
        n_lol      = r_lol;
        n_cl       = r_cl;
        n_hb       = r_hb;
        n_open     = r_open;
        n_err      = r_err;
        n_top_rem  = r_top_rem;
        n_top_tot  = r_top_tot;
        n_ev       = r_ev;
        n_tag      = r_tag;
        n_cls      = r_cls;
        n_cons     = r_cons;
        n_clen     = r_clen;
        n_depth    = r_depth;
        n_closed   = r_closed;
        n_fin      = r_fin;
        n_ecode    = r_ecode;
        mem_we     = 1'b0;
        mem_wrem   = '0;
        fh         = 1'b0;
        fh_len     = '0;
        need       = '0;
        raise      = 1'b0;
        raise_code = dtw_pkg::ERR_NONE;
        show_id    = 1'b1;
        pop_req    = 1'b0;

        if (i_cmd.accept) begin
            n_ev     = dtw_pkg::EV_HEADER;
            n_clen   = '0;
            n_closed = '0;
            n_fin    = 1'b0;
            n_ecode  = dtw_pkg::ERR_NONE;

            if (i_start_req) begin
                // restart on a new outermost identifier
                n_lacc = '0;
                n_lol  = '0;
                n_cl   = '0;
                n_open = '0;
                n_err  = dtw_pkg::ERR_NONE;
                n_id   = i_data_byte;
                n_hb   = 3'd1;
                if (!i_data_byte[dtw_pkg::ID_CONS_BIT]) begin
                    raise      = 1'b1;
                    raise_code = dtw_pkg::ERR_FIRST_PRIM;
                end else begin
                    n_phase = dtw_pkg::PH_LENF;
                end
            end else begin
                unique case (r_phase)
                    dtw_pkg::PH_ID: begin
                        n_id    = i_data_byte;
                        n_hb    = 3'd1;
                        n_phase = dtw_pkg::PH_LENF;
                    end
                    dtw_pkg::PH_LENF: begin
                        n_hb = r_hb + 3'd1;
                        if (!i_data_byte[dtw_pkg::LEN_LONG_BIT]) begin
                            fh     = 1'b1;
                            fh_len = LEN_W'(i_data_byte);
                        end else if (i_data_byte[6:0] == 7'd0) begin
                            // indefinite form reads as length zero
                            fh     = 1'b1;
                            fh_len = '0;
                        end else if (i_data_byte[6:0] > 7'(i_len_limit)) begin
                            raise      = 1'b1;
                            raise_code = dtw_pkg::ERR_LEN_OCTETS;
                        end else begin
                            n_lol   = i_data_byte[LOCT_W-1:0];
                            n_lacc  = '0;
                            n_phase = dtw_pkg::PH_LENM;
                        end
                    end
                    dtw_pkg::PH_LENM: begin
                        n_hb   = r_hb + 3'd1;
                        n_lacc = acc[ACC_W-1:0];
                        n_lol  = lol_dec;
                        if (lol_dec == '0) begin
                            if (acc[31]) begin
                                raise      = 1'b1;
                                raise_code = dtw_pkg::ERR_NEG_LEN;
                            end else begin
                                fh     = 1'b1;
                                fh_len = acc[LEN_W-1:0];
                            end
                        end
                    end
                    dtw_pkg::PH_CONTENT: begin
                        n_ev = dtw_pkg::EV_CONTENT;
                        n_cl = cl_dec;
                        if (cl_dec == '0) begin
                            pop_req = 1'b1;
                        end
                    end
                    default: begin
                        // idle, finished or halted
                        n_ev    = dtw_pkg::EV_IGNORED;
                        show_id = 1'b0;
                        n_fin   = (r_phase == dtw_pkg::PH_DONE);
                        n_ecode = (r_phase == dtw_pkg::PH_ERR) ? r_err : dtw_pkg::ERR_NONE;
                    end
                endcase
            end

            // header complete: check against parent and update the stack
            if (fh) begin
                n_ev   = dtw_pkg::EV_HDR_DONE;
                n_clen = fh_len;
                need   = 32'(fh_len) + 32'(n_hb);
                if (r_open == '0) begin
                    n_top_rem = fh_len;
                    n_top_tot = fh_len;
                    n_open    = DEPTH_W'(1);
                    pop_req   = 1'b1;
                end else if (need > 32'(r_top_rem)) begin
                    raise      = 1'b1;
                    raise_code = dtw_pkg::ERR_OVERRUN;
                end else if (r_id[dtw_pkg::ID_CONS_BIT]) begin
                    if (r_open >= DEPTH_FULL) begin
                        raise      = 1'b1;
                        raise_code = dtw_pkg::ERR_OVERFLOW;
                    end else begin
                        mem_we    = 1'b1;
                        mem_wrem  = r_top_rem - LEN_W'(n_hb);
                        n_top_rem = fh_len;
                        n_top_tot = fh_len;
                        n_open    = r_open + DEPTH_W'(1);
                        pop_req   = 1'b1;
                    end
                end else begin
                    n_top_rem = r_top_rem - need[LEN_W-1:0];
                    n_cl      = fh_len;
                    if (fh_len == '0) begin
                        pop_req = 1'b1;
                    end else begin
                        n_phase = dtw_pkg::PH_CONTENT;
                    end
                end
            end

            // halt on error
            if (raise) begin
                n_phase = dtw_pkg::PH_ERR;
                n_err   = raise_code;
                n_ev    = dtw_pkg::EV_ERROR;
                n_ecode = raise_code;
            end

            n_tag   = show_id ? n_id[TAG_W-1:0] : '0;
            n_cls   = show_id ? n_id[dtw_pkg::ID_CLS_LSB +: CLS_W] : '0;
            n_cons  = show_id ? n_id[dtw_pkg::ID_CONS_BIT] : 1'b0;
            n_depth = CNT_W'(n_open);
        end else if (i_cmd.pop_step) begin
            // close the top level and charge its total to the parent
            n_open   = open_m1;
            n_closed = r_closed + CNT_W'(1);
            if (open_m1 != '0) begin
                n_top_rem = (rd_rem >= r_top_tot) ? (rd_rem - r_top_tot) : '0;
                n_top_tot = rd_tot;
            end
        end else if (i_cmd.finish) begin
            n_phase = (r_open == '0) ? dtw_pkg::PH_DONE : dtw_pkg::PH_ID;
            n_fin   = (r_open == '0);
            n_depth = CNT_W'(r_open);
        end
    end

    assign o_status.pop_req  = pop_req;
    assign o_status.top_zero = (r_open != '0) && (r_top_rem == '0);

    // walker state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= dtw_pkg::PH_IDLE;
            r_id      <= '0;
            r_lacc    <= '0;
            r_lol     <= '0;
            r_cl      <= '0;
            r_hb      <= '0;
            r_open    <= '0;
            r_err     <= dtw_pkg::ERR_NONE;
            r_top_rem <= '0;
            r_top_tot <= '0;
        end else begin
            r_phase   <= n_phase;
            r_id      <= n_id;
            r_lacc    <= n_lacc;
            r_lol     <= n_lol;
            r_cl      <= n_cl;
            r_hb      <= n_hb;
            r_open    <= n_open;
            r_err     <= n_err;
            r_top_rem <= n_top_rem;
            r_top_tot <= n_top_tot;
        end
    end

    // level stack write on push
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_stk_rem[idx_wr] <= mem_wrem;
            r_stk_tot[idx_wr] <= r_top_tot;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_ev     <= n_ev;
        r_tag    <= n_tag;
        r_cls    <= n_cls;
        r_cons   <= n_cons;
        r_clen   <= n_clen;
        r_depth  <= n_depth;
        r_closed <= n_closed;
        r_fin    <= n_fin;
        r_ecode  <= n_ecode;
    end

    assign o_event_res      = r_ev;
    assign o_tag            = r_tag;
    assign o_tag_class      = r_cls;
    assign o_constructed    = r_cons;
    assign o_content_length = r_clen;
    assign o_depth          = r_depth;
    assign o_levels_closed  = r_closed;
    assign o_finished       = r_fin;
    assign o_error_code     = r_ecode;

endmodule

// File: rtl/der_tlv_structure_walker_top.sv
// an octet that completes an outermost, constructed or empty header or ends primitive content
//   and closes k levels runs the level pop sequencer (one pop per cycle) before its result is valid
// throughput: one byte per cycle; input is held while pops run or the result slot is stalled
// reset: synchronous active low; walker idle, no open levels, length octet limit of 4,
//   stack entries are not cleared
// top level: apb configuration register, controller and datapath; depends on dtw_pkg

module der_tlv_structure_walker_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // byte channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [7:0]                      i_data_byte,
    input  logic                            i_start_req,
    // event channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [2:0]                      o_event_res,
    output logic [dtw_pkg::TAG_W-1:0]       o_tag,
    output logic [dtw_pkg::CLS_W-1:0]       o_tag_class,
    output logic                            o_constructed,
    output logic [dtw_pkg::LEN_W-1:0]       o_content_length,
    output logic [dtw_pkg::CNT_W-1:0]       o_depth,
    output logic [dtw_pkg::CNT_W-1:0]       o_levels_closed,
    output logic                            o_finished,
    output logic [2:0]                      o_error_code,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [dtw_pkg::PADDR_W-1:0]     paddr,
    input  logic [dtw_pkg::PDATA_W-1:0]     pwdata,
    output logic [dtw_pkg::PDATA_W-1:0]     prdata,
    output logic                            pready
);

    localparam int LOCT_W  = dtw_pkg::LOCT_W;
    localparam int PADDR_W = dtw_pkg::PADDR_W;
    localparam int PDATA_W = dtw_pkg::PDATA_W;

    logic [LOCT_W-1:0]    r_max_len_oct;
    logic                 reg_sel;
    logic [LOCT_W-1:0]    len_limit;
    dtw_pkg::t_dp_cmd     cmd;
    dtw_pkg::t_dp_status  status;

    // configuration register
    assign pready  = 1'b1;
    assign reg_sel = (paddr[PADDR_W-1:2] == dtw_pkg::REG_MAX_LEN_OCT);
    assign prdata  = reg_sel ? PDATA_W'(r_max_len_oct) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len_oct <= dtw_pkg::MAX_LEN_OCT_RST;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            r_max_len_oct <= pwdata[LOCT_W-1:0];
        end
    end

    // limit in force is the smaller of the register and the design limit
    assign len_limit = (r_max_len_oct < dtw_pkg::LEN_OCT_LIMIT) ? r_max_len_oct
                                                                : dtw_pkg::LEN_OCT_LIMIT;

    dtw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    dtw_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_data_byte      (i_data_byte),
        .i_start_req      (i_start_req),
        .i_len_limit      (len_limit),
        .o_event_res      (o_event_res),
        .o_tag            (o_tag),
        .o_tag_class      (o_tag_class),
        .o_constructed    (o_constructed),
        .o_content_length (o_content_length),
        .o_depth          (o_depth),
        .o_levels_closed  (o_levels_closed),
        .o_finished       (o_finished),
        .o_error_code     (o_error_code)
    );

endmodule
